@@ rtl/tcc_pkg.sv @@
// Shared constants for the tournament core classifier.
`timescale 1ns / 1ps
package tcc_pkg;

  localparam int PATTERN_BITS = 21;
  localparam int CNT_W        = 16;  // exact counts, up to 8! = 40320
  localparam int OUT_W        = 13;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(8191);

  localparam logic [1:0] CLS_CYCLIC  = 2'd0;
  localparam logic [1:0] CLS_TOTAL   = 2'd1;
  localparam logic [1:0] CLS_PARTIAL = 2'd2;

endpackage

@@ rtl/tcc_ram.sv @@
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module tcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tcc_graph.sv @@
// Arc matrix and transitive core from the arc bit pattern.
`timescale 1ns / 1ps
module tcc_graph
  import tcc_pkg::*;
#(
  parameter int VERTICES = 7
) (
  input  logic [PATTERN_BITS-1:0]              pattern,
  output logic [VERTICES-1:0][VERTICES-1:0]    beats,
  output logic [VERTICES-1:0][VERTICES-1:0]    core
);

  always_comb begin
    int pair;
    pair  = 0;
    beats = '0;
    for (int i = 0; i < VERTICES; i++) begin
      for (int j = i + 1; j < VERTICES; j++) begin
        // pairs past the pattern read as 0: higher vertex wins
        if (pair < PATTERN_BITS && pattern[pair]) begin
          beats[i][j] = 1'b1;
        end else begin
          beats[j][i] = 1'b1;
        end
        pair = pair + 1;
      end
    end
  end

  // x->y is in the core if some z closes a transitive triple with it
  always_comb begin
    core = '0;
    for (int x = 0; x < VERTICES; x++) begin
      for (int y = 0; y < VERTICES; y++) begin
        for (int z = 0; z < VERTICES; z++) begin
          if (beats[x][y] &&
              ((beats[y][z] && beats[x][z]) ||
               (beats[z][x] && beats[z][y]) ||
               (beats[x][z] && beats[z][y]))) begin
            core[x][y] = 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ rtl/tournament_core_classifier.sv @@
// Top level: subset dynamic programme over one shared row memory.
// Per item: the arc matrix and core are registered, the empty-set row is written, then
// every vertex of every nonempty subset gets a read step and an accumulate step, then
// the sum step, which waits while a held result is stalled. Input stalls while an
// item is in work.
// The result sits in an output register, so the next item starts at once.
// Reset (synchronous, active high) returns the sequencer to idle, no result.
`timescale 1ns / 1ps
module tournament_core_classifier
  import tcc_pkg::*;
#(
  parameter int VERTICES = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PATTERN_BITS-1:0] arc_pattern,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              core_class,
  output logic [OUT_W-1:0]        extension_count,
  output logic [OUT_W-1:0]        path_count
);

  localparam int VW    = $clog2(VERTICES);
  localparam int ROW_W = (VERTICES + 1) * CNT_W;
  localparam int DEPTH = 1 << VERTICES;
  localparam logic [VERTICES-1:0] FULL = '1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CORE = 6'b000010,
    S_INIT = 6'b000100,
    S_READ = 6'b001000,
    S_ACC  = 6'b010000,
    S_SUM  = 6'b100000
  } state_t;

  state_t state;
  logic [PATTERN_BITS-1:0]           pattern;
  logic [VERTICES-1:0][VERTICES-1:0] beats_c, core_c, beats, core;
  logic [VERTICES-1:0]               m;
  logic [VW-1:0]                     v_idx;
  logic [ROW_W-1:0]                  row_acc, row_next, rdata, wdata;
  logic                              we;
  logic [VERTICES-1:0]               waddr, raddr, sub;
  logic [CNT_W-1:0]                  psum, path_val, ord_add, ext, ptotal;
  logic                              last_v;

  tcc_graph #(.VERTICES(VERTICES)) u_graph (
    .pattern (pattern),
    .beats   (beats_c),
    .core    (core_c)
  );

  tcc_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign sub      = m & ~(VERTICES'(1) << v_idx);
  assign raddr    = sub;
  assign last_v   = (v_idx == VW'(VERTICES - 1));

  // one step: contribution of vertex v_idx placed last in subset m
  always_comb begin
    psum = '0;
    for (int u = 0; u < VERTICES; u++) begin
      if (sub[u] && beats[u][v_idx]) begin
        psum = psum + rdata[(u+1)*CNT_W +: CNT_W];
      end
    end
    if (!m[v_idx]) begin
      path_val = '0;
    end else if (sub == '0) begin
      path_val = CNT_W'(1);
    end else begin
      path_val = psum;
    end
    if (m[v_idx] && ((core[v_idx] & sub) == '0)) begin
      ord_add = rdata[CNT_W-1:0];
    end else begin
      ord_add = '0;
    end
    row_next = row_acc;
    row_next[CNT_W-1:0] = row_acc[CNT_W-1:0] + ord_add;
    for (int u = 0; u < VERTICES; u++) begin
      if (VW'(u) == v_idx) begin
        row_next[(u+1)*CNT_W +: CNT_W] = path_val;
      end
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = m;
    wdata = row_next;
    if (state == S_INIT) begin
      we    = 1'b1;
      waddr = '0;
      wdata = ROW_W'(1);  // empty set: one order, no paths
    end else if (state == S_ACC && last_v) begin
      we = 1'b1;
    end
  end

  always_comb begin
    ext    = row_acc[CNT_W-1:0];
    ptotal = '0;
    for (int u = 0; u < VERTICES; u++) begin
      ptotal = ptotal + row_acc[(u+1)*CNT_W +: CNT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      m         <= '0;
      v_idx     <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_SUM) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pattern <= arc_pattern;
            state   <= S_CORE;
          end
        end
        S_CORE: begin
          beats <= beats_c;
          core  <= core_c;
          state <= S_INIT;
        end
        S_INIT: begin
          m       <= VERTICES'(1);
          v_idx   <= '0;
          row_acc <= '0;
          state   <= S_READ;
        end
        S_READ: begin
          state <= S_ACC;
        end
        S_ACC: begin
          state <= S_READ;
          if (last_v) begin
            v_idx <= '0;
            if (m == FULL) begin
              row_acc <= row_next;
              state   <= S_SUM;
            end else begin
              row_acc <= '0;
              m       <= m + VERTICES'(1);
            end
          end else begin
            row_acc <= row_next;
            v_idx   <= v_idx + VW'(1);
          end
        end
        S_SUM: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (ext == '0) begin
              core_class <= CLS_CYCLIC;
            end else if (ext == CNT_W'(1)) begin
              core_class <= CLS_TOTAL;
            end else begin
              core_class <= CLS_PARTIAL;
            end
            extension_count <= (ext > COUNT_CAP) ? COUNT_CAP[OUT_W-1:0] : ext[OUT_W-1:0];
            path_count <= (ptotal > COUNT_CAP) ? COUNT_CAP[OUT_W-1:0] : ptotal[OUT_W-1:0];
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_read_then_acc: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_ACC)
    else $error("read step not followed by accumulate");
  a_result_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_SUM)
    else $error("result raised outside final step");
  a_cyclic_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && core_class == CLS_CYCLIC) |-> extension_count == '0)
    else $error("cyclic core with nonzero extension count");
  a_total_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && core_class == CLS_TOTAL) |-> extension_count == OUT_W'(1))
    else $error("total order without exactly one extension");
`endif

endmodule
